// ===== rtl/imh_pkg.sv =====
// Shared constants, codes, field offsets and control structs for the indexed max-heap.
// Used by imh_vbits, the core and the checker; depends on nothing.
`default_nettype none

package imh_pkg;

    localparam int NUM_VARS  = 128;
    localparam int KEY_WIDTH = 32;

    localparam int VAR_W  = 7;
    localparam int SLOT_W = $clog2(NUM_VARS);
    localparam int CNT_W  = $clog2(NUM_VARS + 1);
    localparam int OP_W   = 2;
    localparam int STS_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
    localparam logic [STS_W-1:0] STS_PRESENT = 2'd2;

    localparam int IN_OP_LSB   = 0;
    localparam int IN_VAR_LSB  = OP_W;
    localparam int IN_KEY_LSB  = OP_W + VAR_W;
    localparam int IN_W        = OP_W + VAR_W + KEY_WIDTH;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

    localparam int OUT_POP_LSB = 0;
    localparam int OUT_STS_LSB = VAR_W;
    localparam int OUT_MEM_BIT = VAR_W + STS_W;
    localparam int OUT_EMP_BIT = VAR_W + STS_W + 1;
    localparam int OUT_CNT_LSB = VAR_W + STS_W + 2;
    localparam int OUT_W       = VAR_W + STS_W + 2 + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic             key_set;
        logic             pos_set;
        logic             pos_clr;
        logic [VAR_W-1:0] set_idx;
        logic [VAR_W-1:0] clr_idx;
    } t_vb_cmd;

    typedef struct packed {
        logic [VAR_W-1:0] key_idx;
        logic [VAR_W-1:0] pos_idx;
    } t_vb_qry;

    typedef struct packed {
        logic key_vld;
        logic pos_vld;
    } t_vb_rsp;

endpackage

`default_nettype wire

// ===== rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the key, slot and position stores; no dependencies.
`default_nettype none

module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/imh_vbits.sv =====
// Per-variable valid flags: key written and variable present in the heap.
// Depends on imh_pkg for widths and the command, query and response structs.
`default_nettype none

module imh_vbits (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  imh_pkg::t_vb_cmd i_cmd,
    input  imh_pkg::t_vb_qry i_qry,
    output imh_pkg::t_vb_rsp o_rsp
);

    logic [imh_pkg::NUM_VARS-1:0] r_key_vld;
    logic [imh_pkg::NUM_VARS-1:0] r_pos_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
            r_pos_vld <= '0;
        end else begin
            if (i_cmd.key_set) begin
                r_key_vld[imh_pkg::SLOT_W'(i_cmd.set_idx)] <= 1'b1;
            end
            if (i_cmd.pos_set) begin
                r_pos_vld[imh_pkg::SLOT_W'(i_cmd.set_idx)] <= 1'b1;
            end
            if (i_cmd.pos_clr) begin
                r_pos_vld[imh_pkg::SLOT_W'(i_cmd.clr_idx)] <= 1'b0;
            end
        end
    end

    assign o_rsp.key_vld = r_key_vld[imh_pkg::SLOT_W'(i_qry.key_idx)];
    assign o_rsp.pos_vld = r_pos_vld[imh_pkg::SLOT_W'(i_qry.pos_idx)];

endmodule

`default_nettype wire

// ===== rtl/indexed_max_heap_core.sv =====
// Top level of the indexed max-heap: sequencer, shared key comparator, stores, output register.
// Depends on imh_pkg, imh_ram and imh_vbits.
//
//  channel   dir  tdata fields (low bit up)                                  width
//  s_axis    in   operation[1:0] var_index[8:2] key_value[40:9], zero fill    48
//  m_axis    out  popped_var[6:0] status[8:7] member_flag[9] empty_flag[10]
//                 entry_count[18:11], zero fill                                24
//
// Query: S_DEC then S_RESP. Insert and update: S_UP, S_UPS and S_UPK per level climbed.
// Pop: S_PTOP, S_PLAST, S_PKEY, then S_DN to S_DNM per level, at most 6 levels for 128 entries.
// A level climbed reads a slot then a key; a level descended reads both children's slots and keys.
// Each store has one read port. Reset clears the valid flags; no sweep of the stores is needed.
// A held result stalls only the next result, not the next input transfer.
`default_nettype none

module indexed_max_heap_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation, var_index, key_value
    input  wire [imh_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // popped_var, status, member_flag, empty_flag, entry_count
    output logic [imh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_UKEY  = 4'd2;
    localparam logic [3:0] S_UPOS  = 4'd3;
    localparam logic [3:0] S_UP    = 4'd4;
    localparam logic [3:0] S_UPS   = 4'd5;
    localparam logic [3:0] S_UPK   = 4'd6;
    localparam logic [3:0] S_PTOP  = 4'd7;
    localparam logic [3:0] S_PLAST = 4'd8;
    localparam logic [3:0] S_PKEY  = 4'd9;
    localparam logic [3:0] S_DN    = 4'd10;
    localparam logic [3:0] S_DNL   = 4'd11;
    localparam logic [3:0] S_DNR   = 4'd12;
    localparam logic [3:0] S_DNC   = 4'd13;
    localparam logic [3:0] S_DNM   = 4'd14;
    localparam logic [3:0] S_RESP  = 4'd15;

    localparam int VW = imh_pkg::VAR_W;
    localparam int SW = imh_pkg::SLOT_W;
    localparam int CW = imh_pkg::CNT_W;
    localparam int KW = imh_pkg::KEY_WIDTH;

    logic [3:0]                     r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_m_valid, n_m_valid;
    logic [imh_pkg::OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic [imh_pkg::OP_W-1:0]       r_op, n_op;
    logic [VW-1:0]                  r_var, n_var;
    logic [KW-1:0]                  r_key, n_key;
    logic [VW-1:0]                  r_mvar, n_mvar;
    logic [VW-1:0]                  r_cvar, n_cvar;
    logic [VW-1:0]                  r_rvar, n_rvar;
    logic [KW-1:0]                  r_ckey, n_ckey;
    logic [SW-1:0]                  r_slot, n_slot;
    logic [SW-1:0]                  r_child, n_child;
    logic                           r_has_right, n_has_right;
    logic [imh_pkg::STS_W-1:0]      r_status, n_status;
    logic [VW-1:0]                  r_popped, n_popped;
    logic                           r_kvld;

    logic                           key_we;
    logic [SW-1:0]                  key_waddr;
    logic [SW-1:0]                  key_raddr;
    logic [KW-1:0]                  key_rdata;
    logic                           slot_we;
    logic [VW-1:0]                  slot_wdata;
    logic [SW-1:0]                  slot_raddr;
    logic [VW-1:0]                  slot_rdata;
    logic                           pos_we;
    logic [SW-1:0]                  pos_rdata;

    imh_pkg::t_vb_cmd               vb_cmd;
    imh_pkg::t_vb_qry               vb_qry;
    imh_pkg::t_vb_rsp               vb_rsp;

    logic [KW-1:0]                  w_key_rd;
    logic [KW-1:0]                  w_cmp_a, w_cmp_b;
    logic                           w_gt;
    logic                           w_in_range;
    logic [CW:0]                    w_left, w_right, w_cnt_x;
    logic                           w_has_left, w_has_right;
    logic [SW-1:0]                  w_parent;
    logic                           w_accept;

    assign w_key_rd    = r_kvld ? key_rdata : '0;
    assign w_in_range  = CW'(r_var) < CW'(imh_pkg::NUM_VARS);
    assign w_left      = (CW + 1)'({r_slot, 1'b1});
    assign w_right     = w_left + (CW + 1)'(1);
    assign w_cnt_x     = (CW + 1)'(r_count);
    assign w_has_left  = w_left < w_cnt_x;
    assign w_has_right = w_right < w_cnt_x;
    assign w_parent    = SW'((r_slot - SW'(1)) >> 1);
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign key_waddr   = SW'(r_var);
    assign vb_qry.pos_idx = r_var;
    assign vb_qry.key_idx = VW'(key_raddr);

    // shared key comparator
    always_comb begin
        w_cmp_a = r_key;
        w_cmp_b = r_ckey;
        case (r_state)
            S_UPK: begin
                w_cmp_b = w_key_rd;
            end
            S_DNC: begin
                w_cmp_a = w_key_rd;
            end
            default: begin
            end
        endcase
        w_gt = w_cmp_a > w_cmp_b;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_data    = r_m_data;
        n_op        = r_op;
        n_var       = r_var;
        n_key       = r_key;
        n_mvar      = r_mvar;
        n_cvar      = r_cvar;
        n_rvar      = r_rvar;
        n_ckey      = r_ckey;
        n_slot      = r_slot;
        n_child     = r_child;
        n_has_right = r_has_right;
        n_status    = r_status;
        n_popped    = r_popped;

        key_we      = 1'b0;
        key_raddr   = SW'(r_var);
        slot_we     = 1'b0;
        slot_wdata  = r_mvar;
        slot_raddr  = r_child;
        pos_we      = 1'b0;
        vb_cmd      = '0;
        vb_cmd.set_idx = r_var;
        vb_cmd.clr_idx = slot_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = s_axis_tdata[imh_pkg::IN_OP_LSB +: imh_pkg::OP_W];
                    n_var    = s_axis_tdata[imh_pkg::IN_VAR_LSB +: VW];
                    n_key    = s_axis_tdata[imh_pkg::IN_KEY_LSB +: KW];
                    n_status = imh_pkg::STS_OK;
                    n_popped = '0;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_RESP;
                n_mvar  = r_var;
                case (r_op)
                    imh_pkg::OP_INSERT: begin
                        if (w_in_range) begin
                            if (vb_rsp.pos_vld) begin
                                n_status = imh_pkg::STS_PRESENT;
                            end else if (r_count < CW'(imh_pkg::NUM_VARS)) begin
                                vb_cmd.pos_set = 1'b1;
                                n_slot  = SW'(r_count);
                                n_count = r_count + CW'(1);
                                n_state = S_UKEY;
                            end
                        end
                    end
                    imh_pkg::OP_UPDATE: begin
                        if (w_in_range) begin
                            key_we         = 1'b1;
                            vb_cmd.key_set = 1'b1;
                            if (vb_rsp.pos_vld) begin
                                n_state = S_UPOS;
                            end
                        end
                    end
                    imh_pkg::OP_POP: begin
                        if (r_count == '0) begin
                            n_status = imh_pkg::STS_EMPTY;
                        end else begin
                            slot_raddr = '0;
                            n_state    = S_PTOP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UKEY: begin
                n_key   = w_key_rd;
                n_state = S_UP;
            end
            S_UPOS: begin
                n_slot  = pos_rdata;
                n_state = S_UP;
            end
            S_UP: begin
                if (r_slot == '0) begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    slot_raddr = w_parent;
                    n_child    = w_parent;
                    n_state    = S_UPS;
                end
            end
            S_UPS: begin
                n_cvar    = slot_rdata;
                key_raddr = SW'(slot_rdata);
                n_state   = S_UPK;
            end
            S_UPK: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (w_gt) begin
                    slot_wdata = r_cvar;
                    n_slot     = r_child;
                    n_state    = S_UP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PTOP: begin
                n_popped       = slot_rdata;
                vb_cmd.pos_clr = 1'b1;
                n_count        = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = S_RESP;
                end else begin
                    slot_raddr = SW'(r_count - CW'(1));
                    n_state    = S_PLAST;
                end
            end
            S_PLAST: begin
                n_mvar    = slot_rdata;
                key_raddr = SW'(slot_rdata);
                n_state   = S_PKEY;
            end
            S_PKEY: begin
                n_key   = w_key_rd;
                n_slot  = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (!w_has_left) begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    slot_raddr  = w_left[SW-1:0];
                    n_child     = w_left[SW-1:0];
                    n_has_right = w_has_right;
                    n_state     = S_DNL;
                end
            end
            S_DNL: begin
                n_cvar     = slot_rdata;
                key_raddr  = SW'(slot_rdata);
                slot_raddr = r_child + SW'(1);
                n_state    = S_DNR;
            end
            S_DNR: begin
                n_ckey    = w_key_rd;
                n_rvar    = slot_rdata;
                key_raddr = SW'(slot_rdata);
                n_state   = S_DNC;
            end
            S_DNC: begin
                if (r_has_right && w_gt) begin
                    n_cvar  = r_rvar;
                    n_ckey  = w_key_rd;
                    n_child = r_child + SW'(1);
                end
                n_state = S_DNM;
            end
            S_DNM: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (w_gt) begin
                    n_state = S_RESP;
                end else begin
                    slot_wdata = r_cvar;
                    n_slot     = r_child;
                    n_state    = S_DN;
                end
            end
            S_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = imh_pkg::OUT_TDATA_W'({r_count,
                                                       r_count == '0,
                                                       w_in_range && vb_rsp.pos_vld,
                                                       r_status,
                                                       r_popped});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data    <= n_m_data;
        r_op        <= n_op;
        r_var       <= n_var;
        r_key       <= n_key;
        r_mvar      <= n_mvar;
        r_cvar      <= n_cvar;
        r_rvar      <= n_rvar;
        r_ckey      <= n_ckey;
        r_slot      <= n_slot;
        r_child     <= n_child;
        r_has_right <= n_has_right;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_kvld      <= vb_rsp.key_vld;
    end

    imh_vbits u_vbits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (vb_cmd),
        .i_qry   (vb_qry),
        .o_rsp   (vb_rsp)
    );

    imh_ram #(
        .WIDTH (KW),
        .DEPTH (imh_pkg::NUM_VARS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    imh_ram #(
        .WIDTH (VW),
        .DEPTH (imh_pkg::NUM_VARS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    imh_ram #(
        .WIDTH (SW),
        .DEPTH (imh_pkg::NUM_VARS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (SW'(slot_wdata)),
        .i_wdata (r_slot),
        .i_raddr (SW'(r_var)),
        .o_rdata (pos_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/imh_chk.sv =====
// Port-level checker for indexed_max_heap_core, attached by the bind at the end.
// Depends on imh_pkg for field offsets and widths.
`default_nettype none

module imh_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [imh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [imh_pkg::CNT_W-1:0] w_cnt;
    logic [imh_pkg::STS_W-1:0] w_sts;
    logic [imh_pkg::VAR_W-1:0] w_pop;
    logic                      w_emp;

    assign w_cnt = m_axis_tdata[imh_pkg::OUT_CNT_LSB +: imh_pkg::CNT_W];
    assign w_sts = m_axis_tdata[imh_pkg::OUT_STS_LSB +: imh_pkg::STS_W];
    assign w_pop = m_axis_tdata[imh_pkg::OUT_POP_LSB +: imh_pkg::VAR_W];
    assign w_emp = m_axis_tdata[imh_pkg::OUT_EMP_BIT];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_emp == (w_cnt == '0)))
        else $error("empty flag disagrees with entry count");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_cnt <= imh_pkg::CNT_W'(imh_pkg::NUM_VARS)))
        else $error("entry count above capacity");

    a_popempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_sts == imh_pkg::STS_EMPTY) |-> (w_pop == '0) && w_emp)
        else $error("failed pop reports a variable or a non-empty heap");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind indexed_max_heap_core imh_chk u_imh_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
